FILE: sv/bmbe_pkg.sv
// Shared types and constants for the binary mask boundary extractor.
package bmbe_pkg;

    localparam int DEFAULT_MAX_WIDTH = 4096;
    localparam int MAX_HEIGHT        = 4096;
    localparam int CFG_W             = 13;
    localparam int ALPHA_W           = 8;
    localparam int POS_W             = 12;
    localparam int PADDR_W           = 3;
    localparam int PDATA_W           = 32;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] pixel_alpha;
        logic               pad_item;
    } pixel_t;

    typedef struct packed {
        logic             is_border;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             last_result;
    } result_t;

endpackage

FILE: sv/bmbe_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
interface bmbe_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/binary_mask_boundary_extract_top.sv
// Inner boundary extractor for a binary mask, four-neighbour rule.
//
// Pixels enter on the pixels channel in raster order, one transaction per pixel.
// Each result transaction on the results channel describes one pixel: whether it
// is a filled boundary pixel, its column and row, and a flag on the last pixel.
// The answer for a pixel needs the pixel below it, so the first image row gives
// no results and the result for a pixel leaves one row of transactions after it
// entered, through the result register. After the image, software sends one padding
// row of image_width items with pad_item set to flush the last row. Throughput is
// one pixel per cycle while results are taken; the neighborhood test is a few gates
// between the two line stores (read ahead at the next column) and the result
// register. The pixels channel stays ready while the result register is empty or
// being taken, so a stalled receiver holds the current result and stops input.
// Reset clears the counters and sets both registers to 1. The line stores are not
// cleared: entries left from before an image only reach results of its first row,
// where the edge rule alone decides.
// Writing a register through the APB port restarts the image at its first pixel.
module binary_mask_boundary_extract_top #(
    parameter int MAX_WIDTH = bmbe_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    bmbe_stream_if.sink                   pixels,
    bmbe_stream_if.source                 results,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmbe_pkg::PADDR_W-1:0]  paddr,
    input  logic [bmbe_pkg::PDATA_W-1:0]  pwdata,
    output logic [bmbe_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int AW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (EW > bmbe_pkg::CFG_W) ? EW : bmbe_pkg::CFG_W;
    localparam int CW    = bmbe_pkg::CFG_W;

    // Configuration registers
    logic [CW-1:0] width_reg;
    logic [CW-1:0] height_reg;
    logic          cfg_wr;
    logic          cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CW'(1);
            height_reg <= CW'(1);
        end
        else if (cfg_wr)
        begin
            unique case (bmbe_pkg::cfg_reg_t'(cfg_sel))
                bmbe_pkg::REG_IMAGE_WIDTH:  width_reg  <= pwdata[CW-1:0];
                bmbe_pkg::REG_IMAGE_HEIGHT: height_reg <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (bmbe_pkg::cfg_reg_t'(cfg_sel))
            bmbe_pkg::REG_IMAGE_WIDTH:  prdata = bmbe_pkg::PDATA_W'(width_reg);
            bmbe_pkg::REG_IMAGE_HEIGHT: prdata = bmbe_pkg::PDATA_W'(height_reg);
            default:                    prdata = '0;
        endcase
    end

    // Effective (clamped) dimensions
    logic [CMP_W-1:0] width_cmp;
    logic [EW-1:0]    eff_w;
    logic [CW-1:0]    eff_h;

    assign width_cmp = CMP_W'(width_reg);

    always_comb
    begin
        if (width_reg == '0)
            eff_w = EW'(1);
        else if (width_cmp > CMP_W'(MAX_WIDTH))
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = EW'(width_cmp);

        if (height_reg == '0)
            eff_h = CW'(1);
        else if (height_reg > CW'(bmbe_pkg::MAX_HEIGHT))
            eff_h = CW'(bmbe_pkg::MAX_HEIGHT);
        else
            eff_h = height_reg;
    end

    // Position counters
    logic [AW-1:0] col_reg;
    logic [AW-1:0] col_next;
    logic [CW-1:0] row_reg;
    logic [CW-1:0] row_next;
    logic          left_reg;
    logic          left_next;

    logic          in_acc;
    logic          out_free;
    logic [EW-1:0] col_ext;
    logic [EW-1:0] col_plus;
    logic          row_end;

    // Read data of the line stores for the current column, registered ahead from the next column address
    logic          centre_q;
    logic          right_q;
    logic          above_q;

    assign out_free     = !results.valid || results.ready;
    assign pixels.ready = out_free;
    assign in_acc       = pixels.valid && out_free;

    assign col_ext  = EW'(col_reg);
    assign col_plus = col_ext + EW'(1);
    assign row_end  = (col_plus >= eff_w);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        priority if (cfg_wr)
        begin
            col_next  = '0;
            row_next  = '0;
            left_next = 1'b0;
        end
        else if (in_acc)
        begin
            if (row_end)
            begin
                col_next  = '0;
                left_next = 1'b0;
                row_next  = (row_reg >= eff_h) ? '0 : row_reg + CW'(1);
            end
            else
            begin
                col_next  = AW'(col_plus);
                left_next = centre_q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= left_next;
        end
    end

    // Neighborhood test
    logic in_bit;
    logic has_right;
    logic edge_hit;
    logic gap_hit;
    logic border;
    logic is_last;

    assign in_bit    = (row_reg < eff_h) && !pixels.data.pad_item &&
                       (pixels.data.pixel_alpha != '0);
    assign has_right = (col_plus < eff_w) && right_q;
    assign edge_hit  = (col_reg == '0) || row_end || (row_reg == CW'(1)) ||
                       (row_reg == eff_h);
    assign gap_hit   = !left_reg || !has_right || !above_q || !in_bit;
    assign border    = centre_q && (edge_hit || gap_hit);
    assign is_last   = row_end && (row_reg == eff_h);

    // Line stores: one write port each, registered reads with write forwarding
    logic                 above_mem [MAX_WIDTH];
    logic                 centre_mem [MAX_WIDTH];
    logic [EW-1:0]        rd_right_ext;
    logic [AW-1:0]        rd_right;

    assign rd_right_ext = EW'(col_next) + EW'(1);
    assign rd_right     = (rd_right_ext >= EW'(MAX_WIDTH)) ? '0 : AW'(rd_right_ext);

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            above_mem[col_reg]  <= centre_q;
            centre_mem[col_reg] <= in_bit;
        end

        if (in_acc && (col_next == col_reg))
            centre_q <= in_bit;
        else
            centre_q <= centre_mem[col_next];

        if (in_acc && (rd_right == col_reg))
            right_q <= in_bit;
        else
            right_q <= centre_mem[rd_right];

        if (in_acc && (col_next == col_reg))
            above_q <= centre_q;
        else
            above_q <= above_mem[col_next];
    end

    // Result register
    logic             out_valid_next;
    bmbe_pkg::result_t res_next;

    always_comb
    begin
        res_next.is_border   = border;
        res_next.pos_x       = bmbe_pkg::POS_W'(col_reg);
        res_next.pos_y       = bmbe_pkg::POS_W'(row_reg - CW'(1));
        res_next.last_result = is_last;
    end

    always_comb
    begin
        out_valid_next = results.valid;
        if (out_free)
            out_valid_next = in_acc && (row_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results.valid <= 1'b0;
        else
            results.valid <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && (row_reg != '0))
            results.data <= res_next;
    end

    // Checks
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (EW'(col_reg) < eff_w))
        else $error("column counter reached the image width");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= eff_h))
        else $error("row counter passed the padding row");

    a_first_row_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (row_reg == '0) && out_free) |=> !results.valid)
        else $error("an item of the first row produced a result");

    a_result_row: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (row_reg != '0)) |=>
        (results.valid && (results.data.pos_y == bmbe_pkg::POS_W'($past(row_reg) - CW'(1)))))
        else $error("result row does not lag the input row by one");

endmodule

FILE: verif/binary_mask_boundary_extract_top_tb.sv
// Testbench for the binary mask boundary extractor: random masks checked against a predictor.
`timescale 1ns / 1ps

module binary_mask_boundary_extract_top_tb;

    localparam int MAX_W        = bmbe_pkg::DEFAULT_MAX_WIDTH;
    localparam int MAX_H        = bmbe_pkg::MAX_HEIGHT;
    localparam int RANDOM_ITEMS = 1350;
    localparam int BIG_ITEMS    = 100;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 40;

    // Tracks the line stores and counters of the block and queues the expected results.
    class boundary_scoreboard;
        bit              above_row[MAX_W];
        bit              centre_row[MAX_W];
        int unsigned     col;
        int unsigned     row;
        bit              left_bit;
        logic [bmbe_pkg::CFG_W-1:0] width_reg  = 1;
        logic [bmbe_pkg::CFG_W-1:0] height_reg = 1;
        bmbe_pkg::result_t expected_results[$];
        int              errors;
        int              items;

        function int eff_width();
            return (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : int'(width_reg);
        endfunction

        function int eff_height();
            return (height_reg == 0) ? 1 : (height_reg > MAX_H) ? MAX_H : int'(height_reg);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // A register write restarts the image; the line stores are left as they are.
        function void apply_register(bmbe_pkg::cfg_reg_t idx, logic [31:0] value);
            if (idx == bmbe_pkg::REG_IMAGE_WIDTH)
                width_reg = value[bmbe_pkg::CFG_W-1:0];
            else
                height_reg = value[bmbe_pkg::CFG_W-1:0];
            col      = 0;
            row      = 0;
            left_bit = 1'b0;
        endfunction

        function void note_pixel(bmbe_pkg::pixel_t p);
            int unsigned w, h, x, r, y;
            bit          in_bit, centre, right, on_edge, gap;
            bmbe_pkg::result_t res;
            w = eff_width();
            h = eff_height();
            x = (col >= w) ? w - 1 : col;
            r = (row > h) ? h : row;
            items++;
            // Row h is the padding row, where every item counts as empty.
            in_bit = (r < h) && !p.pad_item && (p.pixel_alpha != '0);
            centre = centre_row[x];
            if (r >= 1) begin
                y       = r - 1;
                right   = (x + 1 < w) ? centre_row[x + 1] : 1'b0;
                on_edge = (x == 0) || (x == w - 1) || (y == 0) || (y == h - 1);
                gap     = !left_bit || !right || !above_row[x] || !in_bit;
                res.is_border   = centre && (on_edge || gap);
                res.pos_x       = bmbe_pkg::POS_W'(x);
                res.pos_y       = bmbe_pkg::POS_W'(y);
                res.last_result = (x == w - 1) && (y == h - 1);
                expected_results.push_back(res);
            end
            left_bit      = centre;
            above_row[x]  = centre;
            centre_row[x] = in_bit;
            x++;
            if (x >= w) begin
                x        = 0;
                left_bit = 1'b0;
                r++;
                if (r > h)
                    r = 0;
            end
            col = x;
            row = r;
        endfunction

        function void check_result(bmbe_pkg::result_t got);
            bmbe_pkg::result_t want;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result: border=%0d x=%0d y=%0d last=%0d",
                             $time, got.is_border, got.pos_x, got.pos_y, got.last_result);
                return;
            end
            want = expected_results.pop_front();
            if (got.is_border !== want.is_border || got.pos_x !== want.pos_x ||
                got.pos_y !== want.pos_y || got.last_result !== want.last_result) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result mismatch: expected border=%0d x=%0d y=%0d last=%0d, %s",
                             $time, want.is_border, want.pos_x, want.pos_y, want.last_result,
                             $sformatf("actual border=%0d x=%0d y=%0d last=%0d",
                                       got.is_border, got.pos_x, got.pos_y, got.last_result));
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [bmbe_pkg::PADDR_W-1:0]  paddr;
    logic [bmbe_pkg::PDATA_W-1:0]  pwdata;
    logic [bmbe_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    bmbe_stream_if #(.data_t(bmbe_pkg::pixel_t))  pixel_ch ();
    bmbe_stream_if #(.data_t(bmbe_pkg::result_t)) result_ch ();

    boundary_scoreboard sb = new;

    int          send_gap_pct;
    int          recv_stall_pct;
    int unsigned cycle_count = 0;

    binary_mask_boundary_extract_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixel_ch),
        .results (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: check each transaction, then decide whether to stall the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.data);
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_register(input bmbe_pkg::cfg_reg_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.apply_register(idx, value);
    endtask

    task automatic configure(input logic [31:0] w, input logic [31:0] h);
        write_register(bmbe_pkg::REG_IMAGE_WIDTH, w);
        write_register(bmbe_pkg::REG_IMAGE_HEIGHT, h);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_pixel(input bmbe_pkg::pixel_t p);
        bit idle, hold;
        idle = ($urandom_range(99) < send_gap_pct);
        hold = ($urandom_range(249) == 0);
        if (idle || hold) begin
            pixel_ch.valid <= 1'b0;
            @(posedge clk);
            // Occasionally hold off until every outstanding result has been taken.
            while (hold && sb.pending() != 0) @(posedge clk);
            while ($urandom_range(99) < send_gap_pct) @(posedge clk);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.data  <= p;
        do @(posedge clk); while (!pixel_ch.ready);
        sb.note_pixel(p);
    endtask

    // Sends one image plus its padding row, or stops early after stop_at items.
    task automatic send_image(input int fill_pct, input int noise_pct, input int stop_at);
        int     w, h, n;
        bmbe_pkg::pixel_t p;
        w = sb.eff_width();
        h = sb.eff_height();
        for (n = 0; n < (h + 1) * w && n != stop_at; n++) begin
            p.pixel_alpha = ($urandom_range(99) < fill_pct) ? 8'($urandom_range(255, 1)) : 8'd0;
            p.pad_item    = (n >= h * w);
            if ($urandom_range(99) < noise_pct) begin
                p.pad_item    = ~p.pad_item;
                p.pixel_alpha = 8'($urandom);
            end
            send_pixel(p);
        end
    endtask

    // Drops valid in the step of the last transaction, then waits for all results.
    task automatic wait_drained();
        pixel_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_size(input int typical_max);
        logic [31:0] v;
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = 1;
            2:       v = $urandom_range(typical_max * 4, typical_max + 1);
            default: v = $urandom_range(typical_max, 1);
        endcase
        // Bits above the register width must be dropped by the block.
        if ($urandom_range(3) == 0)
            v[31:bmbe_pkg::CFG_W] = 19'($urandom);
        return v;
    endfunction

    initial
    begin
        int          phase, fill, stop_at, w, h, k;
        int unsigned target;
        logic [31:0] big_w[4];
        logic [31:0] big_h[4];

        big_w = '{4096, 1, 8191, 0};
        big_h = '{3, 4096, 0, 4097};

        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        pixel_ch.valid  <= 1'b0;
        pixel_ch.data   <= '0;
        send_gap_pct    = 15;
        recv_stall_pct  = 83;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset size of one pixel: filled, empty, a pad item inside
        // the image, and an image item inside the padding row.
        send_pixel({8'hFF, 1'b0});
        send_pixel({8'h00, 1'b1});
        send_pixel({8'h00, 1'b0});
        send_pixel({8'h01, 1'b1});
        send_pixel({8'h80, 1'b1});
        send_pixel({8'h07, 1'b0});
        send_pixel({8'h55, 1'b0});
        send_pixel({8'hAA, 1'b0});
        wait_drained();
        // A full 3x3 mask has exactly one inner pixel that is not on the boundary.
        configure(3, 3);
        send_image(100, 0, -1);
        wait_drained();

        for (phase = 0; phase < 3; phase++) begin
            send_gap_pct   = (phase == 0) ? 15 : (phase == 1) ? 83 : 0;
            recv_stall_pct = (phase == 0) ? 83 : (phase == 1) ? 15 : 0;
            if (phase == 2) begin
                // The start of the largest and out-of-range sizes, run without stalls.
                for (k = 0; k < 4; k++) begin
                    configure(big_w[k], big_h[k]);
                    send_image(90, 0, BIG_ITEMS);
                    wait_drained();
                end
            end
            target = sb.items + RANDOM_ITEMS / 3;
            while (sb.items < target) begin
                configure(pick_size(10), pick_size(6));
                w = sb.eff_width();
                h = sb.eff_height();
                for (k = $urandom_range(3, 1); k > 0; k--) begin
                    case ($urandom_range(4))
                        0:       fill = 0;
                        1:       fill = 50;
                        2:       fill = 80;
                        3:       fill = 95;
                        default: fill = 100;
                    endcase
                    stop_at = ($urandom_range(9) == 0) ? $urandom_range((h + 1) * w - 1, 1) : -1;
                    send_image(fill, 4, stop_at);
                    if (stop_at >= 0)
                        break;
                end
                wait_drained();
            end
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
